// ===== hdl/rme_pkg.sv =====
// Shared constants and control types for the modular exponentiation block
package rme_pkg;

	// field and register widths
	localparam int FIELD_W   = 32;
	localparam int WIDTH_DEF = 32;
	localparam int CFG_IDX_W = 1;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 1'd1;

	// register reset values
	localparam logic [FIELD_W-1:0] EXPONENT_RST = 32'd0;
	localparam logic [FIELD_W-1:0] MODULUS_RST  = 32'd1;

	// modular product kinds run on the shared shift-add unit
	localparam logic [1:0] OP_RED = 2'd0;  // reduce the input value
	localparam logic [1:0] OP_MUL = 2'd1;  // result times base
	localparam logic [1:0] OP_SQR = 2'd2;  // base squared

	typedef struct packed {
		logic       load;       // capture a new beat, start the reduction
		logic       op_start;   // start a modular product
		logic [1:0] op_kind;    // which product to start
		logic       step;       // advance the product by one bit
		logic       exp_shift;  // drop the exponent bit just used
		logic       out_load;   // move the answer into the output register
	} cmd_t;

	typedef struct packed {
		logic cnt_last;      // product is on its final bit
		logic m_zero;        // modulus is zero
		logic e_zero;        // remaining exponent is zero
		logic e_lsb;         // current exponent bit
		logic e_upper_zero;  // no exponent bits above the current one
	} sts_t;

endpackage

// ===== hdl/rme_if.sv =====
// Valid/ready channel interfaces for input and result beats
interface rme_in_if;
	logic                        valid;
	logic                        ready;
	logic [rme_pkg::FIELD_W-1:0] value;
	logic                        last;

	modport source (output valid, output value, output last, input ready);
	modport sink (input valid, input value, input last, output ready);
endinterface

interface rme_out_if;
	logic                        valid;
	logic                        ready;
	logic [rme_pkg::FIELD_W-1:0] result_value;
	logic                        result_last;

	modport source (output valid, output result_value, output result_last, input ready);
	modport sink (input valid, input result_value, input result_last, output ready);
endinterface

// ===== hdl/rsa_modular_exponentiation.sv =====
// Top level: configuration registers, controller and datapath of the exponentiator
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    value[31:0], last
//   out_ch   out  valid/ready    result_value[31:0], result_last
//   cfg      in   cfg_we         cfg_index (0 exponent, 1 modulus), cfg_data[31:0]
//
// Each item reduces the input value, then runs a square for each exponent bit below the top set
// bit and a multiply for each set bit; all of these run on the shared shift-add multiplier,
// which takes one operand bit per cycle.
// A zero exponent or zero modulus skips the reduction and the products.
// Reset clears the controller and sets exponent 0, modulus 1; no clearing pass.
// A new beat is taken once the previous answer sits in the output register.
module rsa_modular_exponentiation #(
	parameter int WIDTH = rme_pkg::WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	rme_in_if.sink                        in_ch,
	rme_out_if.source                     out_ch,
	input  logic                          cfg_we,
	input  logic [rme_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rme_pkg::FIELD_W-1:0]   cfg_data
);

	logic [rme_pkg::FIELD_W-1:0] exponent_q;
	logic [rme_pkg::FIELD_W-1:0] modulus_q;
	rme_pkg::cmd_t               cmd;
	rme_pkg::sts_t               sts;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exponent_q <= rme_pkg::EXPONENT_RST;
			modulus_q  <= rme_pkg::MODULUS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				rme_pkg::REG_EXPONENT: exponent_q <= cfg_data;
				rme_pkg::REG_MODULUS:  modulus_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	rme_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	rme_dp #(
		.WIDTH (WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_exponent (exponent_q),
		.cfg_modulus  (modulus_q),
		.in_value     (in_ch.value),
		.in_last      (in_ch.last),
		.result_value (out_ch.result_value),
		.result_last  (out_ch.result_last)
	);

endmodule

// ===== hdl/rme_dp.sv =====
// Datapath: operand registers, shift-add modular multiplier and output register
module rme_dp #(
	parameter int WIDTH = rme_pkg::WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rme_pkg::cmd_t               cmd,
	output rme_pkg::sts_t               sts,
	input  logic [rme_pkg::FIELD_W-1:0] cfg_exponent,
	input  logic [rme_pkg::FIELD_W-1:0] cfg_modulus,
	input  logic [rme_pkg::FIELD_W-1:0] in_value,
	input  logic                        in_last,
	output logic [rme_pkg::FIELD_W-1:0] result_value,
	output logic                        result_last
);

	localparam int ExtW = (WIDTH > rme_pkg::FIELD_W) ? WIDTH : rme_pkg::FIELD_W;
	localparam int CntW = $clog2(WIDTH);

	logic [ExtW-1:0]  exp_ext;
	logic [ExtW-1:0]  mod_ext;
	logic [ExtW-1:0]  val_ext;
	logic [ExtW-1:0]  res_ext;
	logic [WIDTH-1:0] e_in;
	logic [WIDTH-1:0] m_in;

	logic [WIDTH-1:0] e_q;
	logic [WIDTH-1:0] m_q;
	logic [WIDTH-1:0] base_q;
	logic [WIDTH-1:0] res_q;
	logic [WIDTH-1:0] acc_q;
	logic [WIDTH-1:0] a_q;
	logic [WIDTH-1:0] b_q;
	logic [CntW-1:0]  cnt_q;
	logic [1:0]       op_q;
	logic             ez_q;
	logic             last_q;
	logic [rme_pkg::FIELD_W-1:0] out_value_q;
	logic                        out_last_q;

	logic [WIDTH-1:0] a_add;
	logic [WIDTH+1:0] t;
	logic [WIDTH+1:0] mm;
	logic [WIDTH+1:0] mm2;
	logic [WIDTH+1:0] d1;
	logic [WIDTH+1:0] d2;
	logic [WIDTH-1:0] acc_d;
	logic [WIDTH-1:0] answer;

	// take operands in their low WIDTH bits
	assign exp_ext = ExtW'(cfg_exponent);
	assign mod_ext = ExtW'(cfg_modulus);
	assign val_ext = ExtW'(in_value);
	assign e_in    = exp_ext[WIDTH-1:0];
	assign m_in    = mod_ext[WIDTH-1:0];

	// one multiplier bit: acc = 2*acc + (bit ? a : 0), below 3m, then reduce
	always_comb begin
		a_add = b_q[WIDTH-1] ? a_q : '0;
		t     = {1'b0, acc_q, 1'b0} + {2'b00, a_add};
		mm    = {2'b00, m_q};
		mm2   = {1'b0, m_q, 1'b0};
		d1    = t - mm;
		d2    = t - mm2;
		if (t >= mm2) begin
			acc_d = d2[WIDTH-1:0];
		end else if (t >= mm) begin
			acc_d = d1[WIDTH-1:0];
		end else begin
			acc_d = t[WIDTH-1:0];
		end
	end

	// operand and product registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			e_q    <= e_in;
			m_q    <= m_in;
			ez_q   <= (e_in == '0);
			last_q <= in_last;
			res_q  <= WIDTH'(m_in != WIDTH'(1));
			acc_q  <= '0;
			a_q    <= WIDTH'(1);
			b_q    <= val_ext[WIDTH-1:0];
			cnt_q  <= CntW'(WIDTH - 1);
			op_q   <= rme_pkg::OP_RED;
		end else if (cmd.op_start) begin
			acc_q <= '0;
			cnt_q <= CntW'(WIDTH - 1);
			op_q  <= cmd.op_kind;
			case (cmd.op_kind)
				rme_pkg::OP_MUL: begin
					a_q <= res_q;
					b_q <= base_q;
				end
				default: begin
					a_q <= base_q;
					b_q <= base_q;
				end
			endcase
		end else if (cmd.step) begin
			acc_q <= acc_d;
			b_q   <= {b_q[WIDTH-2:0], 1'b0};
			cnt_q <= cnt_q - CntW'(1);
			if (cnt_q == '0) begin
				case (op_q)
					rme_pkg::OP_MUL: res_q  <= acc_d;
					rme_pkg::OP_RED: base_q <= acc_d;
					rme_pkg::OP_SQR: base_q <= acc_d;
					default: ;
				endcase
			end
		end
		if (cmd.exp_shift) begin
			e_q <= e_q >> 1;
		end
	end

	// zero modulus gives 0, zero exponent gives 1
	always_comb begin
		if (m_q == '0) begin
			answer = '0;
		end else if (ez_q) begin
			answer = WIDTH'(1);
		end else begin
			answer = res_q;
		end
	end
	assign res_ext = ExtW'(answer);

	// output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_value_q <= res_ext[rme_pkg::FIELD_W-1:0];
			out_last_q  <= last_q;
		end
	end

	assign result_value     = out_value_q;
	assign result_last      = out_last_q;
	assign sts.cnt_last     = (cnt_q == '0);
	assign sts.m_zero       = (m_q == '0);
	assign sts.e_zero       = (e_q == '0);
	assign sts.e_lsb        = e_q[0];
	assign sts.e_upper_zero = ((e_q >> 1) == '0);

`ifndef SYNTH
	a_acc_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.step) |-> (acc_q < m_q))
		else $error("product accumulator not reduced below modulus");
`endif

endmodule

// ===== hdl/rme_ctrl.sv =====
// Controller: sequences reduction, multiply and square steps and the handshakes
module rme_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output rme_pkg::cmd_t cmd,
	input  rme_pkg::sts_t sts
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_CHECK  = 3'd1;
	localparam logic [2:0] S_RED    = 3'd2;
	localparam logic [2:0] S_PICK   = 3'd3;
	localparam logic [2:0] S_MUL    = 3'd4;
	localparam logic [2:0] S_AFTMUL = 3'd5;
	localparam logic [2:0] S_SQR    = 3'd6;
	localparam logic [2:0] S_DONE   = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.m_zero || sts.e_zero) begin
					state_d = S_DONE;
				end else begin
					state_d = S_RED;
				end
			end
			S_RED: begin
				cmd.step = 1'b1;
				if (sts.cnt_last) begin
					state_d = S_PICK;
				end
			end
			S_PICK: begin
				if (sts.e_zero) begin
					state_d = S_DONE;
				end else if (sts.e_lsb) begin
					cmd.op_start = 1'b1;
					cmd.op_kind  = rme_pkg::OP_MUL;
					state_d      = S_MUL;
				end else begin
					cmd.op_start = 1'b1;
					cmd.op_kind  = rme_pkg::OP_SQR;
					state_d      = S_SQR;
				end
			end
			S_MUL: begin
				cmd.step = 1'b1;
				if (sts.cnt_last) begin
					state_d = S_AFTMUL;
				end
			end
			S_AFTMUL: begin
				// skip the final square once no exponent bits remain
				if (sts.e_upper_zero) begin
					state_d = S_DONE;
				end else begin
					cmd.op_start = 1'b1;
					cmd.op_kind  = rme_pkg::OP_SQR;
					state_d      = S_SQR;
				end
			end
			S_SQR: begin
				cmd.step = 1'b1;
				if (sts.cnt_last) begin
					cmd.exp_shift = 1'b1;
					state_d       = S_PICK;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

`ifndef SYNTH
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result overwritten before it was taken");
	a_accept_check: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_CHECK))
		else $error("accepted beat did not start a check");
	a_step_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (state_q == S_RED || state_q == S_MUL || state_q == S_SQR))
		else $error("product step outside a run state");
`endif

endmodule
